### hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Clock and reset names follow the house ports.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define CHK_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("assertion failed");

`define CHK_IMPLY(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

`else

`define CHK_ALWAYS(lbl, cond)

`define CHK_IMPLY(lbl, pre, post)

`endif

`endif

### hw/rtl/satc_pkg.sv
`timescale 1ns / 1ps

package satc_pkg;

    localparam int DEF_MAX_WAYS    = 8;
    localparam int DEF_MAX_SETS    = 256;
    localparam int DEF_COUNT_WIDTH = 16;

    localparam int TAG_W     = 30;
    localparam int SET_MAX_W = 12;
    localparam int AGE_W     = 4;
    localparam logic [AGE_W-1:0] AGE_MAX = 4'd15;
    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    localparam logic [2:0] OFS_MIN = 3'd2;
    localparam logic [2:0] OFS_MAX = 3'd6;

    typedef enum logic [2:0] {
        CFG_WAYS  = 3'd0,
        CFG_REPL  = 3'd1,
        CFG_WMODE = 3'd2,
        CFG_OFS   = 3'd3,
        CFG_IDX   = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        REPL_LRU  = 2'd0,
        REPL_LFU  = 2'd1,
        REPL_RAND = 2'd2,
        REPL_ALT  = 2'd3
    } t_repl;

    // decoded access passed from front to back
    typedef struct packed {
        logic                 kind;
        logic                 bypass;
        logic [4:0]           nways;
        logic [2:0]           ofs;
        logic [4:0]           shamt;  // offset plus index width
        logic [SET_MAX_W-1:0] set;
        logic [TAG_W-1:0]     tag;
    } t_item;

    typedef struct packed {
        t_repl repl;
        logic  wmode;
    } t_mode;

endpackage

### hw/rtl/satc_front.sv
`timescale 1ns / 1ps

module satc_front #(
    parameter int MAX_WAYS = satc_pkg::DEF_MAX_WAYS,
    parameter int MAX_SETS = satc_pkg::DEF_MAX_SETS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [2:0]        i_cfg_index,
    input  logic [3:0]        i_cfg_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_kind,
    input  logic [31:0]       i_addr,
    output logic              o_q_valid,
    input  logic              i_q_pop,
    output satc_pkg::t_item   o_q_item,
    output satc_pkg::t_mode   o_mode
);

    localparam int MAX_IW = $clog2(MAX_SETS + 1) - 1;

    logic [3:0] r_ways;
    logic [1:0] r_repl;
    logic       r_wmode;
    logic [2:0] r_ofs;
    logic [3:0] r_idx;

    satc_pkg::t_item r_q [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;

    logic [4:0]      nways;
    logic [2:0]      ofs;
    logic [3:0]      iw;
    logic [31:0]     set_full;
    logic [31:0]     tag_full;
    satc_pkg::t_item item;
    logic            push;

    always_comb begin
        nways = ({1'b0, r_ways} > 5'(MAX_WAYS)) ? 5'(MAX_WAYS) : {1'b0, r_ways};
        ofs   = (r_ofs < satc_pkg::OFS_MIN) ? satc_pkg::OFS_MIN :
                (r_ofs > satc_pkg::OFS_MAX) ? satc_pkg::OFS_MAX : r_ofs;
        iw    = (r_idx > 4'(MAX_IW)) ? 4'(MAX_IW) : r_idx;
        set_full = (i_addr >> ofs) & ((32'd1 << iw) - 32'd1);
        tag_full = i_addr >> (5'(ofs) + 5'(iw));
        item.kind   = i_kind;
        item.bypass = (nways == 5'd0);
        item.nways  = nways;
        item.ofs    = ofs;
        item.shamt  = 5'(ofs) + 5'(iw);
        item.set    = set_full[satc_pkg::SET_MAX_W-1:0];
        item.tag    = tag_full[satc_pkg::TAG_W-1:0];
    end

    assign o_ready   = (r_cnt != 2'd2);
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_q[r_rp];
    assign o_mode    = '{repl: satc_pkg::t_repl'(r_repl), wmode: r_wmode};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ways  <= 4'd1;
            r_repl  <= satc_pkg::REPL_LRU;
            r_wmode <= 1'b0;
            r_ofs   <= 3'd2;
            r_idx   <= 4'd0;
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_cnt   <= 2'd0;
        end else begin
            if (i_cfg_valid) begin
                case (satc_pkg::t_cfg_idx'(i_cfg_index))
                    satc_pkg::CFG_WAYS:  r_ways  <= i_cfg_data;
                    satc_pkg::CFG_REPL:  r_repl  <= i_cfg_data[1:0];
                    satc_pkg::CFG_WMODE: r_wmode <= i_cfg_data[0];
                    satc_pkg::CFG_OFS:   r_ofs   <= i_cfg_data[2:0];
                    satc_pkg::CFG_IDX:   r_idx   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            case ({push, i_q_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= item;
        end
    end

endmodule

### hw/rtl/satc_back.sv
`timescale 1ns / 1ps

module satc_back #(
    parameter int MAX_WAYS    = satc_pkg::DEF_MAX_WAYS,
    parameter int MAX_SETS    = satc_pkg::DEF_MAX_SETS,
    parameter int COUNT_WIDTH = satc_pkg::DEF_COUNT_WIDTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    output logic            o_q_pop,
    input  satc_pkg::t_item i_q_item,
    input  satc_pkg::t_mode i_mode,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [39:0]     o_data
);

    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int TW    = satc_pkg::TAG_W;
    localparam int AW    = satc_pkg::AGE_W;

    typedef enum logic [1:0] {
        S_READ,
        S_EXEC,
        S_MOD
    } t_state;

    // set store: one row per set, all ways side by side
    logic [MAX_WAYS-1:0]                  m_valid [MAX_SETS];
    logic [MAX_WAYS-1:0]                  m_dirty [MAX_SETS];
    logic [MAX_WAYS-1:0][TW-1:0]          m_tag   [MAX_SETS];
    logic [MAX_WAYS-1:0][AW-1:0]          m_age   [MAX_SETS];
    logic [MAX_WAYS-1:0][COUNT_WIDTH-1:0] m_cnt   [MAX_SETS];
    logic [MAX_SETS-1:0]                  r_rowv;

    logic [MAX_WAYS-1:0]                  r_v, r_d;
    logic [MAX_WAYS-1:0][TW-1:0]          r_t;
    logic [MAX_WAYS-1:0][AW-1:0]          r_a;
    logic [MAX_WAYS-1:0][COUNT_WIDTH-1:0] r_c;
    logic                                 r_row_ok;

    t_state          r_state;
    satc_pkg::t_item r_item;
    logic [15:0]     r_lfsr;
    logic [15:0]     r_div;
    logic [4:0]      r_rem;
    logic [3:0]      r_bits;
    logic [WAY_W-1:0] r_rand_way;
    logic            r_rand_ok;
    logic            r_ovalid;
    logic [39:0]     r_odata;

    logic [SET_W-1:0] rd_set, wr_set;
    logic             out_free, pop, mem_we, out_load;

    logic [MAX_WAYS-1:0]                  v, d, nv, nd;
    logic [MAX_WAYS-1:0][TW-1:0]          t, nt;
    logic [MAX_WAYS-1:0][AW-1:0]          a, na;
    logic [MAX_WAYS-1:0][COUNT_WIDTH-1:0] c, nc;
    logic [MAX_WAYS-1:0]                  act;
    logic             hit_f, inv_f, need_rand, wb;
    logic [WAY_W-1:0] hw, ivw, lw, fw, way;
    logic [AW-1:0]    last;
    logic [COUNT_WIDTH-1:0] cw;
    logic [31:0]      victim;
    logic [3:0]       way4;
    logic [15:0]      lfsr_nx;
    logic [5:0]       rem_sh;
    logic [5:0]       rem_nx;

    assign out_free = !r_ovalid || i_ready;
    assign rd_set   = i_q_item.set[SET_W-1:0];
    assign wr_set   = r_item.set[SET_W-1:0];
    assign pop      = (r_state == S_READ) && i_q_valid && (!i_q_item.bypass || out_free);
    assign o_q_pop  = pop;
    assign o_valid  = r_ovalid;
    assign o_data   = r_odata;
    // output register gets a new beat this cycle
    assign out_load = (pop && i_q_item.bypass) || mem_we;

    assign lfsr_nx = r_lfsr[0] ? ((r_lfsr >> 1) ^ satc_pkg::LFSR_TAPS) : (r_lfsr >> 1);
    assign rem_sh  = {r_rem, r_div[15]};
    assign rem_nx  = (rem_sh >= 6'(r_item.nways)) ? (rem_sh - 6'(r_item.nways)) : rem_sh;

    always_comb begin
        v = r_row_ok ? r_v : '0;
        d = r_row_ok ? r_d : '0;
        t = r_row_ok ? r_t : '0;
        a = r_row_ok ? r_a : '0;
        c = r_row_ok ? r_c : '0;
        for (int i = 0; i < MAX_WAYS; i++) begin
            act[i] = (5'(i) < r_item.nways);
        end

        hit_f = 1'b0;
        hw    = '0;
        inv_f = 1'b0;
        ivw   = '0;
        for (int i = 0; i < MAX_WAYS; i++) begin
            if (!hit_f && act[i] && v[i] && (t[i] == r_item.tag)) begin
                hit_f = 1'b1;
                hw    = WAY_W'(i);
            end
            if (!inv_f && act[i] && !v[i]) begin
                inv_f = 1'b1;
                ivw   = WAY_W'(i);
            end
        end

        // oldest age and lowest count; ties keep the lower way
        lw = '0;
        fw = '0;
        for (int i = 1; i < MAX_WAYS; i++) begin
            if (act[i] && (a[i] > a[lw])) begin
                lw = WAY_W'(i);
            end
            if (act[i] && (c[i] < c[fw])) begin
                fw = WAY_W'(i);
            end
        end

        need_rand = !hit_f && !inv_f && (i_mode.repl == satc_pkg::REPL_RAND);
        if (hit_f) begin
            way = hw;
        end else if (inv_f) begin
            way = ivw;
        end else begin
            case (i_mode.repl)
                satc_pkg::REPL_LFU:  way = fw;
                satc_pkg::REPL_RAND: way = r_rand_way;
                default:             way = lw;
            endcase
        end

        wb     = !hit_f && v[way] && d[way];
        victim = wb ? ((32'(t[way]) << r_item.shamt) | (32'(r_item.set) << r_item.ofs))
                    : 32'd0;

        nv = v;
        nd = d;
        nt = t;
        nc = c;
        if (!hit_f) begin
            nv[way] = 1'b1;
            nd[way] = 1'b0;
            nt[way] = r_item.tag;
            nc[way] = '0;
        end

        last = (a[way] == '0) ? satc_pkg::AGE_MAX : a[way];
        for (int i = 0; i < MAX_WAYS; i++) begin
            if (WAY_W'(i) == way) begin
                na[i] = AW'(1);
            end else if (act[i] && (a[i] != '0) && (a[i] <= last)
                         && (a[i] < satc_pkg::AGE_MAX)) begin
                na[i] = a[i] + AW'(1);
            end else begin
                na[i] = a[i];
            end
        end

        cw = nc[way];
        if ((i_mode.repl == satc_pkg::REPL_LFU) && (cw != '1)) begin
            nc[way] = cw + COUNT_WIDTH'(1);
        end
        if (r_item.kind) begin
            nd[way] = !i_mode.wmode;
        end

        way4   = 4'(way);
        mem_we = (r_state == S_EXEC) && out_free && !(need_rand && !r_rand_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_READ;
            r_rowv    <= '0;
            r_lfsr    <= satc_pkg::LFSR_SEED;
            r_rand_ok <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            if (r_ovalid && i_ready && !out_load) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_READ: begin
                    if (pop) begin
                        if (i_q_item.bypass) begin
                            r_ovalid <= 1'b1;
                            r_odata  <= {1'b1, 39'd0};
                        end else begin
                            r_state <= S_EXEC;
                        end
                    end
                end
                S_EXEC: begin
                    if (need_rand && !r_rand_ok) begin
                        r_lfsr  <= lfsr_nx;
                        r_div   <= lfsr_nx;
                        r_rem   <= '0;
                        r_bits  <= '0;
                        r_state <= S_MOD;
                    end else if (out_free) begin
                        r_rowv[wr_set] <= 1'b1;
                        r_rand_ok      <= 1'b0;
                        r_ovalid       <= 1'b1;
                        r_odata <= {1'b0, r_item.kind & i_mode.wmode, victim, wb,
                                    !hit_f, way4[2:0], hit_f};
                        r_state <= S_READ;
                    end
                end
                S_MOD: begin
                    // restoring remainder, one bit per cycle
                    r_rem  <= rem_nx[4:0];
                    r_div  <= r_div << 1;
                    r_bits <= r_bits + 4'd1;
                    if (r_bits == 4'd15) begin
                        r_rand_way <= WAY_W'(rem_nx);
                        r_rand_ok  <= 1'b1;
                        r_state    <= S_EXEC;
                    end
                end
                default: r_state <= S_READ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_v      <= m_valid[rd_set];
            r_d      <= m_dirty[rd_set];
            r_t      <= m_tag[rd_set];
            r_a      <= m_age[rd_set];
            r_c      <= m_cnt[rd_set];
            r_row_ok <= r_rowv[rd_set];
            r_item   <= i_q_item;
        end
        if (mem_we) begin
            m_valid[wr_set] <= nv;
            m_dirty[wr_set] <= nd;
            m_tag[wr_set]   <= nt;
            m_age[wr_set]   <= na;
            m_cnt[wr_set]   <= nc;
        end
    end

endmodule

### hw/rtl/set_assoc_cache_tag_controller.sv
`timescale 1ns / 1ps
// Channel  Dir  Beat fields
// s_axis   in   tuser: kind; tdata: address[31:0]
// m_axis   out  tdata: hit, way, fill_needed, writeback_needed,
//               victim_line_address, wr_thru, bypass
// cfg      in   index 0..4, data[3:0]
// An access in the back end takes a set read, then a compare and row write;
// a miss in random mode with all ways valid also passes through the remainder
// unit. A bypass access goes straight to the output register. Tag store rows
// are marked empty by per-set flags at reset, so no clearing pass is needed.
// A 2-beat queue lets the input side keep accepting while the output waits.
`include "assert_macros.svh"

module set_assoc_cache_tag_controller #(
    parameter int MAX_WAYS    = satc_pkg::DEF_MAX_WAYS,
    parameter int MAX_SETS    = satc_pkg::DEF_MAX_SETS,
    parameter int COUNT_WIDTH = satc_pkg::DEF_COUNT_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // address
    input  logic        s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // hit, way[3:1], fill_needed, writeback_needed, victim_line_address[37:6],
    // wr_thru, bypass
    output logic [39:0] m_axis_tdata
);

    logic            q_valid, q_pop;
    satc_pkg::t_item q_item;
    satc_pkg::t_mode mode;

    assign o_cfg_ready = 1'b1;

    satc_front #(
        .MAX_WAYS (MAX_WAYS),
        .MAX_SETS (MAX_SETS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_kind      (s_axis_tuser),
        .i_addr      (s_axis_tdata),
        .o_q_valid   (q_valid),
        .i_q_pop     (q_pop),
        .o_q_item    (q_item),
        .o_mode      (mode)
    );

    satc_back #(
        .MAX_WAYS    (MAX_WAYS),
        .MAX_SETS    (MAX_SETS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .o_q_pop   (q_pop),
        .i_q_item  (q_item),
        .i_mode    (mode),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_data    (m_axis_tdata)
    );

    `CHK_IMPLY(a_bypass_clean, m_axis_tvalid && m_axis_tdata[39], m_axis_tdata[38:0] == 39'd0)
    `CHK_IMPLY(a_hit_no_fill, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[5:4] == 2'b00)
    `CHK_IMPLY(a_wb_on_miss, m_axis_tvalid && m_axis_tdata[5], m_axis_tdata[4])
    `CHK_IMPLY(a_pop_has_data, q_pop, q_valid)

endmodule
